// File: rtl/power_mode_controller_assert.svh
// Assertion macros used by the power mode controller back end.
`ifndef POWER_MODE_CONTROLLER_ASSERT_SVH
`define POWER_MODE_CONTROLLER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define PMC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define PMC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/pmc_pkg.sv
// Shared types, codes and constants of the power mode controller.
package pmc_pkg;

  // Time width default
  localparam int TIME_WIDTH_DEF = 32;

  // Depth of the queue between front and back end
  localparam int QDEPTH = 2;

  // Frame pacing: interval = FRAME_MS / fps
  localparam int QUOT_W = 10;
  localparam logic [QUOT_W-1:0] FRAME_MS = QUOT_W'(1000);

  // Operation codes
  localparam logic [3:0] OP_SCREEN_OFF = 4'd0;
  localparam logic [3:0] OP_SCREEN_ON  = 4'd1;
  localparam logic [3:0] OP_APP_BG     = 4'd2;
  localparam logic [3:0] OP_APP_FG     = 4'd3;
  localparam logic [3:0] OP_LOW_TRIG   = 4'd4;
  localparam logic [3:0] OP_CHG_TRIG   = 4'd5;
  localparam logic [3:0] OP_IDLE_TRIG  = 4'd6;
  localparam logic [3:0] OP_ACTIVITY   = 4'd7;
  localparam logic [3:0] OP_LEVEL      = 4'd8;
  localparam logic [3:0] OP_CHARGING   = 4'd9;
  localparam logic [3:0] OP_FRAME      = 4'd10;
  localparam logic [3:0] OP_SET_MODE   = 4'd11;
  localparam logic [3:0] OP_SET_FPS    = 4'd12;

  // Mode codes
  localparam logic [2:0] MODE_ACTIVE    = 3'd0;
  localparam logic [2:0] MODE_BALANCED  = 3'd1;
  localparam logic [2:0] MODE_POWERSAVE = 3'd2;
  localparam logic [2:0] MODE_SUSPEND   = 3'd3;
  localparam logic [2:0] MODE_HIBERNATE = 3'd4;

  // Register indexes
  localparam logic [2:0] REG_BATT_LOW   = 3'd0;
  localparam logic [2:0] REG_BATT_CRIT  = 3'd1;
  localparam logic [2:0] REG_IDLE_TMO   = 3'd2;
  localparam logic [2:0] REG_PAUSE      = 3'd3;
  localparam logic [2:0] REG_FPS_ACTIVE = 3'd4;
  localparam logic [2:0] REG_FPS_BAL    = 3'd5;
  localparam logic [2:0] REG_FPS_PSAVE  = 3'd6;

  // Register reset values
  localparam logic [6:0]  RST_BATT_LOW   = 7'd20;
  localparam logic [6:0]  RST_BATT_CRIT  = 7'd10;
  localparam logic [31:0] RST_IDLE_TMO   = 32'd300000;
  localparam logic        RST_PAUSE      = 1'b1;
  localparam logic [7:0]  RST_FPS_ACTIVE = 8'd60;
  localparam logic [7:0]  RST_FPS_BAL    = 8'd45;
  localparam logic [7:0]  RST_FPS_PSAVE  = 8'd30;

  // Input beat
  typedef struct packed {
    logic [3:0]  operation;
    logic [31:0] now_ms;
    logic [6:0]  batt_pct;
    logic        charging;
    logic [2:0]  requested_mode;
    logic [7:0]  requested_fps;
  } pmc_in_t;

  // Result beat
  typedef struct packed {
    logic [2:0] mode;
    logic [2:0] old_mode;
    logic       mode_changed;
    logic [7:0] frame_rate;
    logic       battery_alert;
    logic [6:0] alert_level;
    logic       render_frame;
    logic       is_idle;
  } pmc_out_t;

  // Event class decoded by the front end
  typedef struct packed {
    logic screen_wr;
    logic screen_val;
    logic app_wr;
    logic app_val;
    logic touch;
    logic wake;
    logic hide_app;
    logic low_trig;
    logic charge_trig;
    logic idle_trig;
    logic level_wr;
    logic chg_wr;
    logic frame_q;
    logic set_mode;
    logic set_fps;
  } pmc_class_t;

  // Queued command
  typedef struct packed {
    pmc_in_t    item;
    pmc_class_t cls;
  } pmc_cmd_t;

  // Configuration register values
  typedef struct packed {
    logic [6:0]  batt_low;
    logic [6:0]  batt_crit;
    logic [31:0] idle_timeout;
    logic        pause;
    logic [7:0]  rate_act;
    logic [7:0]  rate_bal;
    logic [7:0]  rate_psave;
  } pmc_cfg_t;

  // Configuration write strobe
  typedef struct packed {
    logic       valid;
    logic [2:0] index;
    logic [7:0] data;
  } pmc_cfg_wr_t;

endpackage

// File: rtl/power_mode_controller.sv
// Power mode controller top level: register port, front end and back end.
//
// Events enter through a two-deep queue in the front end, which decodes each
// one; the back end applies them one at a time and holds each result in an
// output register until popped. Other events finish at once. A frame query
// that passes the visibility, mode and rate checks waits for the frame
// interval 1000 / frame_rate from a restoring divider that yields one quotient
// bit per cycle; the back end starts it and finishes the query on its done
// strobe. Registers sit on the APB port at byte address 4 * index; write them
// only while no event is in flight. No clearing pass after reset.
module power_mode_controller #(
  parameter int TIME_WIDTH = pmc_pkg::TIME_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  // Event queue side
  input  logic              push,
  output logic              full,
  input  pmc_pkg::pmc_in_t  item,
  // Result queue side
  output logic              empty,
  input  logic              pop,
  output pmc_pkg::pmc_out_t result,
  // Register port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  pmc_pkg::pmc_cfg_t    cfg;
  pmc_pkg::pmc_cfg_wr_t cfg_wr;
  pmc_pkg::pmc_cmd_t    q_cmd;
  logic                 q_valid;
  logic                 q_pop;
  logic [2:0]           reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];

  // Register write beat
  assign cfg_wr.valid = psel && penable && pwrite && pready;
  assign cfg_wr.index = reg_idx;
  assign cfg_wr.data  = pwdata[7:0];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.batt_low      <= pmc_pkg::RST_BATT_LOW;
      cfg.batt_crit     <= pmc_pkg::RST_BATT_CRIT;
      cfg.idle_timeout  <= pmc_pkg::RST_IDLE_TMO;
      cfg.pause         <= pmc_pkg::RST_PAUSE;
      cfg.rate_act      <= pmc_pkg::RST_FPS_ACTIVE;
      cfg.rate_bal      <= pmc_pkg::RST_FPS_BAL;
      cfg.rate_psave    <= pmc_pkg::RST_FPS_PSAVE;
    end else if (cfg_wr.valid) begin
      case (reg_idx)
        pmc_pkg::REG_BATT_LOW:   cfg.batt_low      <= pwdata[6:0];
        pmc_pkg::REG_BATT_CRIT:  cfg.batt_crit     <= pwdata[6:0];
        pmc_pkg::REG_IDLE_TMO:   cfg.idle_timeout  <= pwdata;
        pmc_pkg::REG_PAUSE:      cfg.pause         <= pwdata[0];
        pmc_pkg::REG_FPS_ACTIVE: cfg.rate_act      <= pwdata[7:0];
        pmc_pkg::REG_FPS_BAL:    cfg.rate_bal      <= pwdata[7:0];
        pmc_pkg::REG_FPS_PSAVE:  cfg.rate_psave    <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Register read mux
  always_comb begin
    case (reg_idx)
      pmc_pkg::REG_BATT_LOW:   prdata = {25'd0, cfg.batt_low};
      pmc_pkg::REG_BATT_CRIT:  prdata = {25'd0, cfg.batt_crit};
      pmc_pkg::REG_IDLE_TMO:   prdata = cfg.idle_timeout;
      pmc_pkg::REG_PAUSE:      prdata = {31'd0, cfg.pause};
      pmc_pkg::REG_FPS_ACTIVE: prdata = {24'd0, cfg.rate_act};
      pmc_pkg::REG_FPS_BAL:    prdata = {24'd0, cfg.rate_bal};
      pmc_pkg::REG_FPS_PSAVE:  prdata = {24'd0, cfg.rate_psave};
      default:                 prdata = 32'd0;
    endcase
  end

  pmc_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .item    (item),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .q_cmd   (q_cmd)
  );

  pmc_back #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .q_pop   (q_pop),
    .cfg     (cfg),
    .cfg_wr  (cfg_wr),
    .pop     (pop),
    .empty   (empty),
    .result  (result)
  );

endmodule

// File: rtl/pmc_front.sv
// Front end: decodes incoming events and queues them for the back end.
module pmc_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  pmc_pkg::pmc_in_t  item,
  output logic              q_valid,
  input  logic              q_pop,
  output pmc_pkg::pmc_cmd_t q_cmd
);

  localparam int PW = (pmc_pkg::QDEPTH > 1) ? $clog2(pmc_pkg::QDEPTH) : 1;
  localparam int CNTW = $clog2(pmc_pkg::QDEPTH + 1);

  pmc_pkg::pmc_cmd_t q [pmc_pkg::QDEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CNTW-1:0] count;
  pmc_pkg::pmc_class_t cls;
  logic do_push;
  logic do_pop;

  // Event classification
  always_comb begin
    cls = '0;
    case (item.operation)
      pmc_pkg::OP_SCREEN_OFF: begin
        cls.screen_wr = 1'b1;
      end
      pmc_pkg::OP_SCREEN_ON: begin
        cls.screen_wr  = 1'b1;
        cls.screen_val = 1'b1;
        cls.touch      = 1'b1;
        cls.wake       = 1'b1;
      end
      pmc_pkg::OP_APP_BG: begin
        cls.app_wr   = 1'b1;
        cls.hide_app = 1'b1;
      end
      pmc_pkg::OP_APP_FG: begin
        cls.app_wr  = 1'b1;
        cls.app_val = 1'b1;
        cls.touch   = 1'b1;
        cls.wake    = 1'b1;
      end
      pmc_pkg::OP_LOW_TRIG:  cls.low_trig    = 1'b1;
      pmc_pkg::OP_CHG_TRIG:  cls.charge_trig = 1'b1;
      pmc_pkg::OP_IDLE_TRIG: cls.idle_trig   = 1'b1;
      pmc_pkg::OP_ACTIVITY:  cls.touch       = 1'b1;
      pmc_pkg::OP_LEVEL:     cls.level_wr    = 1'b1;
      pmc_pkg::OP_CHARGING:  cls.chg_wr      = 1'b1;
      pmc_pkg::OP_FRAME:     cls.frame_q     = 1'b1;
      pmc_pkg::OP_SET_MODE:  cls.set_mode    = 1'b1;
      pmc_pkg::OP_SET_FPS:   cls.set_fps     = 1'b1;
      default:               cls = '0;
    endcase
  end

  assign full    = (count == CNTW'(pmc_pkg::QDEPTH));
  assign q_valid = (count != '0);
  assign do_push = push && !full;
  assign do_pop  = q_pop && q_valid;
  assign q_cmd   = q[rd_ptr];

  // Queue storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wr_ptr] <= '{item: item, cls: cls};
    end
  end

  // Queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(pmc_pkg::QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(pmc_pkg::QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: rtl/pmc_div.sv
// Restoring divider for the frame interval: FRAME_MS / fps, one bit a cycle.
module pmc_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [7:0]                 divisor,
  output logic                       done,
  output logic [pmc_pkg::QUOT_W-1:0] quotient
);

  localparam int CW = $clog2(pmc_pkg::QUOT_W + 1);

  logic [pmc_pkg::QUOT_W-1:0] dvd;
  logic [7:0]  rem;
  logic [7:0]  dvs;
  logic [CW-1:0] cnt;
  logic        busy;
  logic [8:0]  rem_sh;
  logic [8:0]  rem_sub;
  logic        fits;

  // One restoring step
  always_comb begin
    rem_sh  = {rem, dvd[pmc_pkg::QUOT_W-1]};
    fits    = (rem_sh >= {1'b0, dvs});
    rem_sub = rem_sh - {1'b0, dvs};
  end

  assign quotient = dvd;

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(pmc_pkg::QUOT_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: quotient bits shift in where the dividend shifts out
  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= pmc_pkg::FRAME_MS;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      dvd <= {dvd[pmc_pkg::QUOT_W-2:0], fits};
      rem <= fits ? rem_sub[7:0] : rem_sh[7:0];
    end
  end

endmodule

// File: rtl/pmc_back.sv
// Back end: applies queued events to the controller state and forms results.
module pmc_back #(
  parameter int TIME_WIDTH = pmc_pkg::TIME_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  input  pmc_pkg::pmc_cmd_t    q_cmd,
  output logic                 q_pop,
  input  pmc_pkg::pmc_cfg_t    cfg,
  input  pmc_pkg::pmc_cfg_wr_t cfg_wr,
  input  logic                 pop,
  output logic                 empty,
  output pmc_pkg::pmc_out_t    result
);

  localparam int CW = (TIME_WIDTH > 32) ? TIME_WIDTH : 32;

  // Back-end states
  localparam logic S_RUN = 1'b0;
  localparam logic S_DIV = 1'b1;

  logic state;
  logic out_valid;

  // Controller state
  logic [2:0]            cur_mode;
  logic [7:0]            fps_target;
  logic                  scr_on;
  logic                  app_front;
  logic [6:0]            batt_lvl;
  logic                  charger_on;
  logic [TIME_WIDTH-1:0] last_act;
  logic [TIME_WIDTH-1:0] last_frame;

  // Next-state values
  logic [2:0]            mode_next;
  logic [7:0]            fps_next;
  logic                  screen_next;
  logic                  app_next;
  logic [6:0]            batt_next;
  logic                  chg_next;
  logic [TIME_WIDTH-1:0] last_act_next;

  pmc_pkg::pmc_in_t    it;
  pmc_pkg::pmc_class_t cl;
  pmc_pkg::pmc_out_t   res_next;
  logic [TIME_WIDTH-1:0] now_t;
  logic [TIME_WIDTH-1:0] act_diff;
  logic [TIME_WIDTH-1:0] frame_diff;
  logic       req_en;
  logic [2:0] req_mode;
  logic       crit;
  logic       low;
  logic       alert;
  logic       eval_batt;
  logic       frame_ok;
  logic       render;
  logic       is_idle;
  logic       slot_free;
  logic       go;
  logic       res_load;
  logic       div_start;
  logic       div_done;
  logic [pmc_pkg::QUOT_W-1:0] div_quot;

  // Target rate for a mode
  function automatic logic [7:0] fps_for_mode(input pmc_pkg::pmc_cfg_t c,
                                              input logic [2:0] m);
    logic [7:0] f;
    case (m)
      pmc_pkg::MODE_ACTIVE:    f = c.rate_act;
      pmc_pkg::MODE_BALANCED:  f = c.rate_bal;
      pmc_pkg::MODE_POWERSAVE: f = c.rate_psave;
      default:                 f = 8'd0;
    endcase
    return f;
  endfunction

  pmc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .divisor  (fps_target),
    .done     (div_done),
    .quotient (div_quot)
  );

  assign it = q_cmd.item;
  assign cl = q_cmd.cls;
  assign now_t = TIME_WIDTH'(it.now_ms);

  // Mode request from the event
  always_comb begin
    req_en    = 1'b0;
    req_mode  = cur_mode;
    alert     = 1'b0;
    batt_next = cl.level_wr ? it.batt_pct : batt_lvl;
    crit      = (batt_next <= cfg.batt_crit);
    low       = (batt_next <= cfg.batt_low);
    eval_batt = cl.level_wr || (cl.chg_wr && !it.charging);

    if (cl.wake && (cur_mode == pmc_pkg::MODE_SUSPEND)) begin
      req_en   = 1'b1;
      req_mode = pmc_pkg::MODE_ACTIVE;
    end
    if (cl.hide_app && cfg.pause) begin
      req_en   = 1'b1;
      req_mode = pmc_pkg::MODE_POWERSAVE;
    end
    if (cl.low_trig) begin
      if (crit) begin
        req_en   = 1'b1;
        req_mode = pmc_pkg::MODE_POWERSAVE;
      end else if (low) begin
        req_en   = 1'b1;
        req_mode = pmc_pkg::MODE_BALANCED;
      end
    end
    if (cl.charge_trig || (cl.chg_wr && it.charging)) begin
      req_en   = 1'b1;
      req_mode = pmc_pkg::MODE_ACTIVE;
    end
    if (cl.idle_trig && !app_front && !scr_on) begin
      req_en   = 1'b1;
      req_mode = pmc_pkg::MODE_SUSPEND;
    end
    if (eval_batt) begin
      if (crit) begin
        alert    = 1'b1;
        req_en   = 1'b1;
        req_mode = pmc_pkg::MODE_POWERSAVE;
      end else if (low) begin
        alert = 1'b1;
        if (cur_mode == pmc_pkg::MODE_ACTIVE) begin
          req_en   = 1'b1;
          req_mode = pmc_pkg::MODE_BALANCED;
        end
      end
    end
    if (cl.set_mode) begin
      req_en   = 1'b1;
      req_mode = it.requested_mode;
    end
  end

  // Mode entry, flags, times and result
  always_comb begin
    mode_next = cur_mode;
    fps_next  = fps_target;
    if (req_en && (req_mode <= pmc_pkg::MODE_HIBERNATE) && (req_mode != cur_mode)) begin
      mode_next = req_mode;
      fps_next  = fps_for_mode(cfg, req_mode);
    end
    if (cl.set_fps) begin
      fps_next = it.requested_fps;
    end

    screen_next   = cl.screen_wr ? cl.screen_val : scr_on;
    app_next      = cl.app_wr ? cl.app_val : app_front;
    chg_next      = cl.chg_wr ? it.charging : charger_on;
    last_act_next = cl.touch ? now_t : last_act;

    act_diff = now_t - last_act_next;
    is_idle  = (CW'(act_diff) >= CW'(cfg.idle_timeout));

    // Frame pacing applies only when visible and rendering
    frame_ok = cl.frame_q
            && (cur_mode != pmc_pkg::MODE_SUSPEND)
            && (cur_mode != pmc_pkg::MODE_HIBERNATE)
            && !(cfg.pause && (!app_front || !scr_on))
            && (fps_target != 8'd0);
    frame_diff = now_t - last_frame;
    render     = (state == S_DIV) && (frame_diff >= TIME_WIDTH'(div_quot));

    res_next.mode          = mode_next;
    res_next.old_mode      = cur_mode;
    res_next.mode_changed  = (mode_next != cur_mode);
    res_next.frame_rate    = fps_next;
    res_next.battery_alert = alert;
    res_next.alert_level   = batt_next;
    res_next.render_frame  = render;
    res_next.is_idle       = is_idle;
  end

  // Sequencing: plain events finish at once, paced frame queries divide first
  assign slot_free = !out_valid || pop;
  assign go        = (state == S_RUN) && q_valid && slot_free;
  assign div_start = go && frame_ok;
  assign res_load  = (go && !frame_ok) || ((state == S_DIV) && div_done);
  assign q_pop     = res_load;
  assign empty     = !out_valid;

  // Control and controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_RUN;
      out_valid   <= 1'b0;
      cur_mode    <= pmc_pkg::MODE_ACTIVE;
      fps_target  <= pmc_pkg::RST_FPS_ACTIVE;
      scr_on      <= 1'b1;
      app_front   <= 1'b1;
      batt_lvl    <= '0;
      charger_on  <= 1'b0;
      last_act    <= '0;
      last_frame  <= '0;
    end else begin
      if (div_start) begin
        state <= S_DIV;
      end else if (res_load) begin
        state <= S_RUN;
      end

      if (res_load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end

      if (res_load) begin
        cur_mode    <= mode_next;
        fps_target  <= fps_next;
        scr_on      <= screen_next;
        app_front   <= app_next;
        batt_lvl    <= batt_next;
        charger_on  <= chg_next;
        last_act    <= last_act_next;
        if (render) begin
          last_frame <= now_t;
        end
      end else if (cfg_wr.valid) begin
        // Writing the current mode's rate register reloads the target when no result loads
        if (((cfg_wr.index == pmc_pkg::REG_FPS_ACTIVE) &&
             (cur_mode == pmc_pkg::MODE_ACTIVE)) ||
            ((cfg_wr.index == pmc_pkg::REG_FPS_BAL) &&
             (cur_mode == pmc_pkg::MODE_BALANCED)) ||
            ((cfg_wr.index == pmc_pkg::REG_FPS_PSAVE) &&
             (cur_mode == pmc_pkg::MODE_POWERSAVE))) begin
          fps_target <= cfg_wr.data;
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (res_load) begin
      result <= res_next;
    end
  end

`include "power_mode_controller_assert.svh"

  `PMC_ASSERT_NOW(a_load_free, res_load, !out_valid || pop, "result overwritten before taken")
  `PMC_ASSERT_NOW(a_done_in_div, div_done, state == S_DIV, "divider done outside frame wait")
  `PMC_ASSERT_NOW(a_div_holds_item, state == S_DIV, q_valid, "frame query left queue early")
  `PMC_ASSERT_NEXT(a_div_waits, (state == S_DIV) && !div_done, state == S_DIV, "left wait early")

endmodule

// File: tb/power_mode_controller_tb.sv
// Self-checking testbench for the power mode controller: directed and random events.
`timescale 1ns / 1ps

module power_mode_controller_tb;

  localparam int FRAME_PERIOD_MS = 1000;
  localparam int MAX_PRINTED     = 100;

  // DUT ports, driven inputs known from time zero
  logic              clk     = 1'b0;
  logic              rst     = 1'b1;
  logic              push    = 1'b0;
  logic              full;
  pmc_pkg::pmc_in_t  ev_beat = '0;
  logic              empty;
  logic              pop     = 1'b0;
  pmc_pkg::pmc_out_t status_beat;
  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [4:0]        paddr   = '0;
  logic [31:0]       pwdata  = '0;
  logic [31:0]       prdata;
  logic              pready;

  power_mode_controller dut (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .item    (ev_beat),
    .empty   (empty),
    .pop     (pop),
    .result  (status_beat),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Mirror of the controller state and registers
  pmc_pkg::pmc_cfg_t cfg;
  logic [2:0]  mode_now;
  logic [7:0]  fps_now;
  logic        display_on;
  logic        app_front;
  logic [6:0]  batt_level;
  logic        on_charger;
  logic [31:0] t_activity;
  logic [31:0] t_frame;

  pmc_pkg::pmc_out_t expected_status[$];
  int          error_count = 0;
  int          pop_hold    = 0;
  bit          no_idle     = 1'b0;
  logic [31:0] ms_clock    = '0;

  // ---------------------------------------------------------------- predictor

  function automatic void reset_model();
    cfg.batt_low      = 7'd20;
    cfg.batt_crit     = 7'd10;
    cfg.idle_timeout  = 32'd300000;
    cfg.pause         = 1'b1;
    cfg.rate_act      = 8'd60;
    cfg.rate_bal      = 8'd45;
    cfg.rate_psave    = 8'd30;
    mode_now   = pmc_pkg::MODE_ACTIVE;
    fps_now    = 8'd60;
    display_on = 1'b1;
    app_front  = 1'b1;
    batt_level = '0;
    on_charger = 1'b0;
    t_activity = '0;
    t_frame    = '0;
  endfunction

  // Entering the current or an unknown mode is a no-op
  function automatic void switch_mode(logic [2:0] m);
    if (m > pmc_pkg::MODE_HIBERNATE || m == mode_now) return;
    mode_now = m;
    case (m)
      pmc_pkg::MODE_ACTIVE:    fps_now = cfg.rate_act;
      pmc_pkg::MODE_BALANCED:  fps_now = cfg.rate_bal;
      pmc_pkg::MODE_POWERSAVE: fps_now = cfg.rate_psave;
      default:                 fps_now = 8'd0;
    endcase
  endfunction

  // Level evaluation shared by level and charger-off reports
  function automatic logic battery_check();
    if (batt_level <= cfg.batt_crit) begin
      switch_mode(pmc_pkg::MODE_POWERSAVE);
      return 1'b1;
    end
    if (batt_level <= cfg.batt_low) begin
      if (mode_now == pmc_pkg::MODE_ACTIVE) switch_mode(pmc_pkg::MODE_BALANCED);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic pmc_pkg::pmc_out_t apply_event(pmc_pkg::pmc_in_t ev);
    pmc_pkg::pmc_out_t st;
    logic [2:0] prev;
    logic       alert;
    logic       render;
    logic [31:0] interval;
    prev   = mode_now;
    alert  = 1'b0;
    render = 1'b0;
    case (ev.operation)
      pmc_pkg::OP_SCREEN_OFF: display_on = 1'b0;
      pmc_pkg::OP_SCREEN_ON: begin
        display_on = 1'b1;
        t_activity = ev.now_ms;
        if (mode_now == pmc_pkg::MODE_SUSPEND) switch_mode(pmc_pkg::MODE_ACTIVE);
      end
      pmc_pkg::OP_APP_BG: begin
        app_front = 1'b0;
        if (cfg.pause) switch_mode(pmc_pkg::MODE_POWERSAVE);
      end
      pmc_pkg::OP_APP_FG: begin
        app_front  = 1'b1;
        t_activity = ev.now_ms;
        if (mode_now == pmc_pkg::MODE_SUSPEND) switch_mode(pmc_pkg::MODE_ACTIVE);
      end
      pmc_pkg::OP_LOW_TRIG: begin
        if (batt_level <= cfg.batt_crit) switch_mode(pmc_pkg::MODE_POWERSAVE);
        else if (batt_level <= cfg.batt_low) switch_mode(pmc_pkg::MODE_BALANCED);
      end
      pmc_pkg::OP_CHG_TRIG: switch_mode(pmc_pkg::MODE_ACTIVE);
      pmc_pkg::OP_IDLE_TRIG: begin
        if (!app_front && !display_on) switch_mode(pmc_pkg::MODE_SUSPEND);
      end
      pmc_pkg::OP_ACTIVITY: t_activity = ev.now_ms;
      pmc_pkg::OP_LEVEL: begin
        batt_level = ev.batt_pct;
        alert      = battery_check();
      end
      pmc_pkg::OP_CHARGING: begin
        on_charger = ev.charging;
        if (ev.charging) switch_mode(pmc_pkg::MODE_ACTIVE);
        else alert = battery_check();
      end
      pmc_pkg::OP_FRAME: begin
        // no frame when asleep, hidden with pause set, or at 0 fps
        if (mode_now != pmc_pkg::MODE_SUSPEND && mode_now != pmc_pkg::MODE_HIBERNATE &&
            !(cfg.pause && (!app_front || !display_on)) && fps_now != 8'd0) begin
          interval = FRAME_PERIOD_MS / fps_now;
          if (ev.now_ms - t_frame >= interval) begin
            t_frame = ev.now_ms;
            render  = 1'b1;
          end
        end
      end
      pmc_pkg::OP_SET_MODE: switch_mode(ev.requested_mode);
      pmc_pkg::OP_SET_FPS:  fps_now = ev.requested_fps;
      default: ;
    endcase
    st.mode          = mode_now;
    st.old_mode      = prev;
    st.mode_changed  = (mode_now != prev);
    st.frame_rate    = fps_now;
    st.battery_alert = alert;
    st.alert_level   = batt_level;
    st.render_frame  = render;
    st.is_idle       = (ev.now_ms - t_activity >= cfg.idle_timeout);
    return st;
  endfunction

  function automatic logic [31:0] register_value(logic [2:0] idx);
    case (idx)
      pmc_pkg::REG_BATT_LOW:   return 32'(cfg.batt_low);
      pmc_pkg::REG_BATT_CRIT:  return 32'(cfg.batt_crit);
      pmc_pkg::REG_IDLE_TMO:   return cfg.idle_timeout;
      pmc_pkg::REG_PAUSE:      return 32'(cfg.pause);
      pmc_pkg::REG_FPS_ACTIVE: return 32'(cfg.rate_act);
      pmc_pkg::REG_FPS_BAL:    return 32'(cfg.rate_bal);
      default:                 return 32'(cfg.rate_psave);
    endcase
  endfunction

  function automatic void store_register(logic [2:0] idx, logic [31:0] val);
    case (idx)
      pmc_pkg::REG_BATT_LOW:  cfg.batt_low     = val[6:0];
      pmc_pkg::REG_BATT_CRIT: cfg.batt_crit    = val[6:0];
      pmc_pkg::REG_IDLE_TMO:  cfg.idle_timeout = val;
      pmc_pkg::REG_PAUSE:     cfg.pause        = val[0];
      pmc_pkg::REG_FPS_ACTIVE: begin
        cfg.rate_act = val[7:0];
        if (mode_now == pmc_pkg::MODE_ACTIVE) fps_now = val[7:0];
      end
      pmc_pkg::REG_FPS_BAL: begin
        cfg.rate_bal = val[7:0];
        if (mode_now == pmc_pkg::MODE_BALANCED) fps_now = val[7:0];
      end
      default: begin
        cfg.rate_psave = val[7:0];
        if (mode_now == pmc_pkg::MODE_POWERSAVE) fps_now = val[7:0];
      end
    endcase
  endfunction

  // ---------------------------------------------------------------- helpers

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (error_count < MAX_PRINTED)
      $display("[%0t] mismatch %s: got %0h, want %0h", $realtime, what, got, want);
    error_count++;
  endtask

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Send one event beat; push stays high if the next beat follows at once
  task automatic send_event(pmc_pkg::pmc_in_t ev);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push    <= 1'b1;
    ev_beat <= ev;
    do @(posedge clk); while (full);
    expected_status.push_back(apply_event(ev));
  endtask

  // Stop pushing and wait until every status beat has been popped
  task automatic wait_idle();
    push <= 1'b0;
    @(posedge clk);
    while (expected_status.size() != 0) @(posedge clk);
  endtask

  // APB write followed by a read-back of the same register
  task automatic write_register(logic [2:0] idx, logic [31:0] val);
    logic [31:0] want;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 5'(idx) << 2;
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    store_register(idx, val);
    want = register_value(idx);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want) report_mismatch("register read", prdata, want);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_config(logic [6:0] low, logic [6:0] crit, logic [31:0] idle,
                                logic pause, logic [7:0] fa, logic [7:0] fb,
                                logic [7:0] fp);
    wait_idle();
    write_register(pmc_pkg::REG_BATT_LOW, 32'(low));
    write_register(pmc_pkg::REG_BATT_CRIT, 32'(crit));
    write_register(pmc_pkg::REG_IDLE_TMO, idle);
    write_register(pmc_pkg::REG_PAUSE, 32'(pause));
    write_register(pmc_pkg::REG_FPS_ACTIVE, 32'(fa));
    write_register(pmc_pkg::REG_FPS_BAL, 32'(fb));
    write_register(pmc_pkg::REG_FPS_PSAVE, 32'(fp));
  endtask

  function automatic pmc_pkg::pmc_in_t make_event(logic [3:0] op, logic [31:0] now,
                                                  logic [6:0] lvl, logic chg,
                                                  logic [2:0] rmode, logic [7:0] rfps);
    pmc_pkg::pmc_in_t ev;
    ev.operation      = op;
    ev.now_ms         = now;
    ev.batt_pct       = lvl;
    ev.charging       = chg;
    ev.requested_mode = rmode;
    ev.requested_fps  = rfps;
    return ev;
  endfunction

  // Time mostly creeps forward, sometimes jumps or lands anywhere
  function automatic logic [31:0] next_time();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) ms_clock = ms_clock + $urandom_range(0, 40);
    else if (r < 90) ms_clock = ms_clock + $urandom_range(0, 2000);
    else if (r < 95) ms_clock = ms_clock + $urandom();
    else if (r < 98) ms_clock = 32'hFFFF_FF00 + $urandom_range(0, 255);
    else ms_clock = $urandom();
    return ms_clock;
  endfunction

  // Battery levels cluster at the thresholds
  function automatic logic [6:0] pick_level();
    case ($urandom_range(0, 5))
      0: return cfg.batt_crit;
      1: return cfg.batt_crit + 7'd1;
      2: return cfg.batt_low;
      3: return cfg.batt_low + 7'd1;
      4: return 7'($urandom_range(0, 100));
      default: return 7'($urandom_range(0, 127));
    endcase
  endfunction

  function automatic pmc_pkg::pmc_in_t random_event(logic [3:0] op);
    logic [2:0] rmode;
    rmode = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
    return make_event(op, next_time(), pick_level(), 1'($urandom_range(0, 1)), rmode,
                      8'($urandom_range(0, 255)));
  endfunction

  function automatic logic [3:0] pick_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return pmc_pkg::OP_FRAME;
    if (r < 34) return 4'($urandom_range(13, 15));
    return 4'($urandom_range(0, 12));
  endfunction

  // ---------------------------------------------------------------- checker

  task automatic compare_status(pmc_pkg::pmc_out_t got);
    pmc_pkg::pmc_out_t want;
    if (expected_status.size() == 0) begin
      report_mismatch("unexpected status beat", 32'(got), '0);
      return;
    end
    want = expected_status.pop_front();
    if (got.mode !== want.mode)
      report_mismatch("mode", 32'(got.mode), 32'(want.mode));
    if (got.old_mode !== want.old_mode)
      report_mismatch("old_mode", 32'(got.old_mode), 32'(want.old_mode));
    if (got.mode_changed !== want.mode_changed)
      report_mismatch("mode_changed", 32'(got.mode_changed), 32'(want.mode_changed));
    if (got.frame_rate !== want.frame_rate)
      report_mismatch("frame_rate", 32'(got.frame_rate), 32'(want.frame_rate));
    if (got.battery_alert !== want.battery_alert)
      report_mismatch("battery_alert", 32'(got.battery_alert), 32'(want.battery_alert));
    if (got.alert_level !== want.alert_level)
      report_mismatch("alert_level", 32'(got.alert_level), 32'(want.alert_level));
    if (got.render_frame !== want.render_frame)
      report_mismatch("render_frame", 32'(got.render_frame), 32'(want.render_frame));
    if (got.is_idle !== want.is_idle)
      report_mismatch("is_idle", 32'(got.is_idle), 32'(want.is_idle));
  endtask

  // Pop side: check each accepted beat, then stall at random
  always @(posedge clk) begin
    if (!rst) begin
      if (pop && !empty) begin
        compare_status(status_beat);
        pop_hold = pick_gap();
      end
      if (pop_hold > 0) begin
        pop_hold--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- tests

  // Extremes, every operation and the open cases at reset settings
  task automatic test_directed_events();
    send_event(make_event(pmc_pkg::OP_FRAME, 32'd0, 7'd0, 1'b0, 3'd0, 8'd0));
    send_event(make_event(pmc_pkg::OP_FRAME, 32'd16, 7'd127, 1'b1, 3'd7, 8'd255));
    send_event(make_event(pmc_pkg::OP_ACTIVITY, 32'hFFFF_FFFF, 7'd0, 1'b0, 3'd0, 8'd0));
    // frame time wraps past zero
    send_event(make_event(pmc_pkg::OP_FRAME, 32'd5, 7'd0, 1'b0, 3'd0, 8'd0));
    send_event(make_event(pmc_pkg::OP_SCREEN_OFF, 32'd10, 7'd0, 1'b0, 3'd0, 8'd0));
    send_event(make_event(pmc_pkg::OP_FRAME, 32'd100, 7'd0, 1'b0, 3'd0, 8'd0));
    send_event(make_event(pmc_pkg::OP_APP_BG, 32'd110, 7'd0, 1'b0, 3'd0, 8'd0));
    send_event(make_event(pmc_pkg::OP_IDLE_TRIG, 32'd120, 7'd0, 1'b0, 3'd0, 8'd0));
    send_event(make_event(pmc_pkg::OP_FRAME, 32'd500, 7'd0, 1'b0, 3'd0, 8'd0));
    // entering the current mode
    send_event(make_event(pmc_pkg::OP_SET_MODE, 32'd510, 7'd0, 1'b0,
                          pmc_pkg::MODE_SUSPEND, 8'd0));
    send_event(make_event(pmc_pkg::OP_SCREEN_ON, 32'd520, 7'd0, 1'b0, 3'd0, 8'd0));
    send_event(make_event(pmc_pkg::OP_APP_FG, 32'd530, 7'd0, 1'b0, 3'd0, 8'd0));
    // level above a hundred, then critical, then low
    send_event(make_event(pmc_pkg::OP_LEVEL, 32'd540, 7'd127, 1'b0, 3'd0, 8'd0));
    send_event(make_event(pmc_pkg::OP_LEVEL, 32'd550, 7'd0, 1'b0, 3'd0, 8'd0));
    send_event(make_event(pmc_pkg::OP_LEVEL, 32'd560, 7'd15, 1'b0, 3'd0, 8'd0));
    send_event(make_event(pmc_pkg::OP_CHARGING, 32'd570, 7'd0, 1'b1, 3'd0, 8'd0));
    send_event(make_event(pmc_pkg::OP_CHARGING, 32'd580, 7'd0, 1'b0, 3'd0, 8'd0));
    send_event(make_event(pmc_pkg::OP_LOW_TRIG, 32'd590, 7'd0, 1'b0, 3'd0, 8'd0));
    send_event(make_event(pmc_pkg::OP_CHG_TRIG, 32'd600, 7'd0, 1'b0, 3'd0, 8'd0));
    send_event(make_event(pmc_pkg::OP_SET_MODE, 32'd610, 7'd0, 1'b0,
                          pmc_pkg::MODE_HIBERNATE, 8'd0));
    // unknown modes are ignored
    send_event(make_event(pmc_pkg::OP_SET_MODE, 32'd620, 7'd0, 1'b0, 3'd7, 8'd0));
    send_event(make_event(pmc_pkg::OP_SET_MODE, 32'd630, 7'd0, 1'b0, 3'd5, 8'd0));
    send_event(make_event(pmc_pkg::OP_SET_MODE, 32'd640, 7'd0, 1'b0,
                          pmc_pkg::MODE_ACTIVE, 8'd0));
    send_event(make_event(pmc_pkg::OP_SET_FPS, 32'd650, 7'd0, 1'b0, 3'd0, 8'd0));
    send_event(make_event(pmc_pkg::OP_FRAME, 32'd2000, 7'd0, 1'b0, 3'd0, 8'd0));
    send_event(make_event(pmc_pkg::OP_SET_FPS, 32'd2010, 7'd0, 1'b0, 3'd0, 8'd255));
    send_event(make_event(pmc_pkg::OP_FRAME, 32'd2013, 7'd0, 1'b0, 3'd0, 8'd0));
    // unknown operations only report status; idle just short of the timeout
    send_event(make_event(4'd13, 32'd300000, 7'd0, 1'b0, 3'd0, 8'd0));
    send_event(make_event(4'd15, 32'd299999, 7'd0, 1'b0, 3'd0, 8'd0));
  endtask

  // Zero fps registers load a zero target and block rendering
  task automatic test_zero_fps_register();
    program_config(7'd20, 7'd10, 32'd300000, 1'b1, 8'd0, 8'd0, 8'd0);
    send_event(make_event(pmc_pkg::OP_FRAME, 32'd5000, 7'd0, 1'b0, 3'd0, 8'd0));
    send_event(make_event(pmc_pkg::OP_SET_MODE, 32'd5010, 7'd0, 1'b0,
                          pmc_pkg::MODE_BALANCED, 8'd0));
    send_event(make_event(pmc_pkg::OP_FRAME, 32'd6000, 7'd0, 1'b0, 3'd0, 8'd0));
    send_event(make_event(pmc_pkg::OP_SET_MODE, 32'd6010, 7'd0, 1'b0,
                          pmc_pkg::MODE_POWERSAVE, 8'd0));
    send_event(make_event(pmc_pkg::OP_FRAME, 32'd7000, 7'd0, 1'b0, 3'd0, 8'd0));
    ms_clock = 32'd7000;
  endtask

  // Random events with well-formed suspend and wake sequences mixed in
  task automatic test_random_events(int count);
    int sent;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 9) == 0) begin
        send_event(random_event(pmc_pkg::OP_SCREEN_OFF));
        send_event(random_event(pmc_pkg::OP_APP_BG));
        send_event(random_event(pmc_pkg::OP_IDLE_TRIG));
        send_event(random_event(pmc_pkg::OP_FRAME));
        send_event(random_event($urandom_range(0, 1) ? pmc_pkg::OP_SCREEN_ON
                                                     : pmc_pkg::OP_APP_FG));
        sent += 5;
      end else begin
        send_event(random_event(pick_op()));
        sent++;
      end
    end
  endtask

  task automatic test_random_settings();
    program_config(7'($urandom_range(0, 100)), 7'($urandom_range(0, 100)),
                   32'($urandom_range(0, 3000)), 1'($urandom_range(0, 1)),
                   8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                   8'($urandom_range(1, 255)));
    test_random_events(200);
  endtask

  // ---------------------------------------------------------------- main

  initial begin
    reset_model();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_events();
    test_zero_fps_register();

    // reset settings
    program_config(7'd20, 7'd10, 32'd300000, 1'b1, 8'd60, 8'd45, 8'd30);
    test_random_events(200);

    // upper extremes, idle at once, no pause
    program_config(7'd100, 7'd100, 32'd0, 1'b0, 8'd255, 8'd255, 8'd255);
    test_random_events(180);

    // lower extremes, idle never
    program_config(7'd0, 7'd0, 32'hFFFF_FFFF, 1'b1, 8'd1, 8'd1, 8'd1);
    test_random_events(180);

    test_random_settings();
    test_random_settings();

    // back-to-back beats on both sides
    no_idle = 1'b1;
    program_config(7'd50, 7'd25, 32'd1000, 1'b1, 8'd120, 8'd90, 8'd15);
    test_random_events(200);
    no_idle = 1'b0;

    wait_idle();
    repeat (20) @(posedge clk);
    if (error_count == 0 && expected_status.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Run limit
  initial begin
    #8000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/pmc_pkg.sv
rtl/pmc_front.sv
rtl/pmc_div.sv
rtl/pmc_back.sv
rtl/power_mode_controller.sv
tb/power_mode_controller_tb.sv
